// File: hdl/ebe_pkg.sv
// ebe_pkg: constants, types and helpers for the byte entropy estimator
// used by every file under hdl; no dependencies
package ebe_pkg;

  localparam int COUNT_BITS = 20;
  localparam int BIN_COUNT  = 256;
  localparam int BIN_W      = $clog2(BIN_COUNT);
  localparam int LOG_FRAC   = 24;
  localparam int OUT_FRAC   = 16;
  localparam int KW         = $clog2(COUNT_BITS);
  localparam int LOG_W      = KW + LOG_FRAC;
  localparam int SUM_W      = COUNT_BITS + LOG_W;
  localparam int FIELD_W    = 20;
  localparam int RND_SH     = LOG_FRAC - OUT_FRAC;
  localparam int ITER_W     = $clog2(LOG_FRAC);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [FIELD_W-1:0]    FIELD_MAX   = {FIELD_W{1'b1}};
  localparam logic [FIELD_W-1:0]    ENTROPY_MAX = FIELD_W'(8 << OUT_FRAC);
  localparam logic [BIN_W-1:0]      LAST_BIN    = BIN_W'(BIN_COUNT - 1);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [LOG_W-1:0]      log_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [BIN_W-1:0]      bin_t;

  typedef struct packed {
    logic cnt;
    logic clr;
    bin_t addr;
  } hist_req_t;

  typedef struct packed {
    logic done;
    log_t value;
  } log_rsp_t;

  typedef enum logic [3:0] {
    S_INIT, S_COUNT, S_DRAIN, S_LOGN, S_RD, S_RDW, S_LOGC, S_MUL, S_ACC, S_DIV, S_DONE
  } state_t;

  function automatic logic [FIELD_W-1:0] sat_field(input count_t v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'(FIELD_MAX)) ? FIELD_MAX : w[FIELD_W-1:0];
  endfunction

endpackage

// File: hdl/ebe_if.sv
// ebe_in_if / ebe_out_if: valid-ready channels for input and result items
// depends on ebe_pkg
interface ebe_in_if;
  import ebe_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_present;
  logic       last_byte;
  modport source (output valid, byte_value, byte_present, last_byte, input ready);
  modport sink (input valid, byte_value, byte_present, last_byte, output ready);
endinterface

interface ebe_out_if;
  import ebe_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] entropy_bits;
  logic [FIELD_W-1:0] bytes_counted;
  logic               count_overflow;
  modport source (output valid, entropy_bits, bytes_counted, count_overflow, input ready);
  modport sink (input valid, entropy_bits, bytes_counted, count_overflow, output ready);
endinterface

// File: hdl/ebe_hist.sv
// ebe_hist: histogram memory with read-modify-write increment and clear port
// depends on ebe_pkg
module ebe_hist
  import ebe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  hist_req_t req,
  output count_t    rd_data
);

  count_t mem [BIN_COUNT];
  count_t rd_q_r;
  logic   s1_v_r;
  bin_t   s1_addr_r;
  logic   fwd_v_r;
  bin_t   fwd_addr_r;
  count_t fwd_data_r;
  count_t base;
  count_t inc;

  assign base    = (fwd_v_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : rd_q_r;
  assign inc     = base + count_t'(1);
  assign rd_data = rd_q_r;

  always_ff @(posedge clk) begin
    rd_q_r <= mem[req.addr];
    if (s1_v_r) begin
      mem[s1_addr_r] <= inc;
    end else if (req.clr) begin
      mem[req.addr] <= '0;
    end
    s1_addr_r  <= req.addr;
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r  <= req.cnt;
      fwd_v_r <= s1_v_r;
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(req.cnt && req.clr))
    else $error("count and clear at once");
  a_noclr_wr: assert property (@(posedge clk) disable iff (!rst_n) s1_v_r |-> !req.clr)
    else $error("clear while increment pending");
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n) fwd_v_r |-> $past(s1_v_r))
    else $error("forward without write");

endmodule

// File: hdl/ebe_log2.sv
// ebe_log2: iterative fixed-point log2, one squaring per cycle
// depends on ebe_pkg
module ebe_log2
  import ebe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  count_t   x,
  output logic     busy,
  output log_rsp_t rsp
);

  logic              busy_r;
  logic [ITER_W-1:0] it_r;
  logic [31:0]       m_r;
  log_t              r_r;
  logic              done_r;
  logic [KW-1:0]     k;
  logic [63:0]       sq;
  logic [32:0]       t;

  always_comb begin
    k = '0;
    for (int i = 0; i < COUNT_BITS; i++) begin
      if (x[i]) k = KW'(i);
    end
  end

  assign sq = 64'(m_r) * 64'(m_r);
  assign t  = sq[63:31];

  always_ff @(posedge clk) begin
    if (start) begin
      m_r <= 32'(x) << (6'd31 - 6'(k));
      r_r <= {k, {LOG_FRAC{1'b0}}};
    end else if (busy_r) begin
      m_r <= t[32] ? t[32:1] : t[31:0];
      r_r[ITER_W'(LOG_FRAC - 1) - it_r] <= t[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      it_r   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        it_r <= it_r + ITER_W'(1);
        if (it_r == ITER_W'(LOG_FRAC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy      = busy_r;
  assign rsp.done  = done_r;
  assign rsp.value = r_r;

endmodule

// File: hdl/ebe_div.sv
// ebe_div: restoring divider, one quotient bit per cycle
// depends on ebe_pkg
module ebe_div
  import ebe_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  sum_t   dividend,
  input  count_t divisor,
  output logic   done,
  output sum_t   quotient
);

  localparam int CW = $clog2(SUM_W + 1);

  sum_t                q_r;
  logic [COUNT_BITS:0] rem_r;
  count_t              dv_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [COUNT_BITS:0] rem_s;
  logic                ge;

  assign rem_s = {rem_r[COUNT_BITS-1:0], q_r[SUM_W-1]};
  assign ge    = rem_s >= {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_s - {1'b0, dv_r} : rem_s;
      q_r   <= {q_r[SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: hdl/byte_entropy_estimator_unit.sv
// byte_entropy_estimator_unit: shannon entropy of a byte buffer, Q4.16
// depends on ebe_pkg, ebe_if, ebe_hist, ebe_log2, ebe_div
//
// usage: bytes arrive on in_item, one item per cycle while counting. each
// present byte increments its bin of a 256-entry histogram memory (read,
// increment, write back with forwarding). the item with last_byte set closes
// the buffer; the block then stops taking items and, if any byte was counted,
// takes log2 of the byte total and sweeps all 256 bins, clearing each as it
// reads it. a nonzero bin passes through read, squaring log2, multiply and
// accumulate, an empty bin through the read steps only; with no bytes counted
// the result is zero. the sum is then divided bit-serially by the byte total.
// the result sits in an output register on out_item; counting of the next
// buffer starts as soon as the result is loaded, even while out_item is
// stalled, but a further result waits until the previous one has been taken.
// reset: synchronous, active low; afterwards all 256 bins of the histogram
// are cleared in turn, during which in_item.ready stays low.
module byte_entropy_estimator_unit
  import ebe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ebe_in_if.sink     in_item,
  ebe_out_if.source  out_item
);

  state_t    state_r, state_nxt;
  bin_t      idx_r, idx_nxt;
  count_t    total_r, total_nxt;
  logic      ovf_r, ovf_nxt;
  log_t      ln_r, ln_nxt;
  count_t    c_r, c_nxt;
  log_t      d_r, d_nxt;
  sum_t      prod_r, prod_nxt;
  sum_t      sum_r, sum_nxt;
  logic [FIELD_W-1:0] ent_r, ent_nxt;

  logic               ov_r;
  logic [FIELD_W-1:0] oe_r, ob_r;
  logic               oo_r;
  logic               load;

  hist_req_t hreq;
  count_t    rd_data;
  logic      lg_start, lg_busy;
  count_t    lg_x;
  log_rsp_t  lg_rsp;
  logic      dv_start, dv_done;
  sum_t      quo;
  logic [SUM_W:0] q_rnd;
  logic      acc;
  logic      counted;

  ebe_hist u_hist (.clk, .rst_n, .req(hreq), .rd_data);
  ebe_log2 u_log (.clk, .rst_n, .start(lg_start), .x(lg_x), .busy(lg_busy), .rsp(lg_rsp));
  ebe_div u_div (.clk, .rst_n, .start(dv_start), .dividend(sum_nxt), .divisor(total_r),
                 .done(dv_done), .quotient(quo));

  assign in_item.ready = (state_r == S_COUNT);
  assign acc     = in_item.valid && in_item.ready;
  assign counted = acc && in_item.byte_present && (total_r != COUNT_MAX);
  assign q_rnd   = ({1'b0, quo} + (SUM_W+1)'(1 << (RND_SH - 1))) >> RND_SH;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    total_nxt = total_r;
    ovf_nxt   = ovf_r;
    ln_nxt    = ln_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    prod_nxt  = prod_r;
    sum_nxt   = sum_r;
    ent_nxt   = ent_r;
    hreq      = '{cnt: 1'b0, clr: 1'b0, addr: idx_r};
    lg_start  = 1'b0;
    lg_x      = total_r;
    dv_start  = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      S_INIT: begin
        hreq.clr = 1'b1;
        idx_nxt  = idx_r + bin_t'(1);
        if (idx_r == LAST_BIN) state_nxt = S_COUNT;
      end
      S_COUNT: begin
        hreq.addr = in_item.byte_value;
        hreq.cnt  = counted;
        if (counted) total_nxt = total_r + count_t'(1);
        if (acc && in_item.byte_present && total_r == COUNT_MAX) ovf_nxt = 1'b1;
        if (acc && in_item.last_byte) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        sum_nxt = '0;
        idx_nxt = '0;
        if (total_r == '0) begin
          ent_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          lg_start  = 1'b1;
          state_nxt = S_LOGN;
        end
      end
      S_LOGN: begin
        if (lg_rsp.done) begin
          ln_nxt    = lg_rsp.value;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        hreq.clr  = 1'b1;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        c_nxt = rd_data;
        if (rd_data == '0) begin
          idx_nxt = idx_r + bin_t'(1);
          if (idx_r == LAST_BIN) begin
            dv_start  = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          lg_x      = rd_data;
          lg_start  = 1'b1;
          state_nxt = S_LOGC;
        end
      end
      S_LOGC: begin
        if (lg_rsp.done) begin
          d_nxt     = (ln_r > lg_rsp.value) ? ln_r - lg_rsp.value : '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = SUM_W'(c_r) * SUM_W'(d_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        sum_nxt = sum_r + prod_r;
        idx_nxt = idx_r + bin_t'(1);
        if (idx_r == LAST_BIN) begin
          state_nxt = S_DIV;
          dv_start  = 1'b1;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_DIV: begin
        if (dv_done) begin
          ent_nxt   = (q_rnd > (SUM_W+1)'(ENTROPY_MAX)) ? ENTROPY_MAX : q_rnd[FIELD_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || out_item.ready) begin
          load      = 1'b1;
          total_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_COUNT;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      idx_r   <= '0;
      total_r <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
      ovf_r   <= ovf_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_item.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ln_r   <= ln_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    ent_r  <= ent_nxt;
    if (load) begin
      oe_r <= ent_r;
      ob_r <= sat_field(total_r);
      oo_r <= ovf_r;
    end
  end

  assign out_item.valid          = ov_r;
  assign out_item.entropy_bits   = oe_r;
  assign out_item.bytes_counted  = ob_r;
  assign out_item.count_overflow = oo_r;

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (oe_r <= ENTROPY_MAX))
    else $error("entropy out of range");
  a_log_start: assert property (@(posedge clk) disable iff (!rst_n)
    lg_start |-> !lg_busy)
    else $error("log2 restarted while busy");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> (state_r == S_DIV))
    else $error("divide result outside divide state");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (total_r == '0 && !ovf_r && ov_r))
    else $error("buffer state not cleared after result");

endmodule
